// ===== src/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that a signal holds in the cycle after a condition.
`define ASSERT_HOLD(lbl, clk, rst_n, cond, sig, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) cond |=> $stable(sig)) \
        else $error(msg);

`endif

// ===== src/mrow_pkg.sv =====
// Types and constants for the multi-reader overwrite ring.
`timescale 1ns / 1ps
`default_nettype none

package mrow_pkg;

    localparam int READERS   = 4;
    localparam int SLOT_W    = 2;
    localparam int WORD_W    = 32;
    localparam int REQ_LEN_W = 16;
    localparam int MAX_LINE  = 256;
    localparam int LEN_W     = 8;
    localparam int FILL_W    = 8;

    localparam logic [LEN_W-1:0] LINE_LEN_MAX = LEN_W'(MAX_LINE - 1);

    typedef enum logic [1:0] {
        CMD_WRITE = 2'd0,
        CMD_ALLOC = 2'd1,
        CMD_FREE  = 2'd2,
        CMD_READ  = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NO_READER = 2'd1,
        ST_NOTHING   = 2'd2,
        ST_EMPTY     = 2'd3
    } status_t;

endpackage

`default_nettype wire

// ===== src/multi_reader_overwrite_ring.sv =====
// Overwrite-oldest ring shared by several readers, one request per cycle while
// the output is not stalled. Each result is registered in the p_* stage, then in
// the out_* output stage. Throughput: one request per cycle when not stalled;
// the single ring memory port is read or written at most once per request, with
// the read data registered. Reset: clears write index, fill count, reader lags,
// reader activity and all valid flags; ring memory contents are not cleared.
`timescale 1ns / 1ps
`default_nettype none

module multi_reader_overwrite_ring
    import mrow_pkg::*;
#(
    parameter int DEPTH = 128
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // line_word[31:0], line_length[47:32], reader_slot[49:48], zero[55:50]
    input  wire logic [55:0] s_tdata,
    // cmd[1:0]
    input  wire logic [1:0]  s_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // status[1:0], granted_slot[3:2], read_word[35:4], read_length[43:36],
    // pending_mask[47:44], fill_level[55:48]
    output logic [55:0]      m_tdata
);

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LAG_W = $clog2(DEPTH + 1);
    localparam logic [LAG_W-1:0] DEPTH_L = LAG_W'(DEPTH);

    logic [WORD_W-1:0] words_mem [DEPTH];
    logic [LEN_W-1:0]  lengths_mem [DEPTH];

    logic [IDX_W-1:0]  wr_idx_reg, wr_idx_next;
    logic [LAG_W-1:0]  fill_reg, fill_next;
    logic [LAG_W-1:0]  lag_reg [READERS];
    logic [LAG_W-1:0]  lag_next [READERS];
    logic [READERS-1:0] active_reg, active_next;

    logic              p_valid_reg;
    status_t           p_status_reg, p_status_next;
    logic [SLOT_W-1:0] p_slot_reg, p_slot_next;
    logic              p_hit_reg, p_hit_next;
    logic [READERS-1:0] p_pend_reg, p_pend_next;
    logic [FILL_W-1:0] p_fill_reg;
    logic [WORD_W-1:0] rd_word_reg;
    logic [LEN_W-1:0]  rd_len_reg;

    logic              out_valid_reg;
    status_t           out_status_reg;
    logic [SLOT_W-1:0] out_slot_reg;
    logic [WORD_W-1:0] out_word_reg;
    logic [LEN_W-1:0]  out_len_reg;
    logic [READERS-1:0] out_pend_reg;
    logic [FILL_W-1:0] out_fill_reg;

    logic              advance;
    logic              accept;
    cmd_t              cmd_in;
    logic [WORD_W-1:0] word_in;
    logic [REQ_LEN_W-1:0] req_len_in;
    logic [SLOT_W-1:0] slot_in;
    logic [LEN_W-1:0]  len_clamped;
    logic              do_write;
    logic              do_read;
    logic [LAG_W-1:0]  lag_sel;
    logic [LAG_W:0]    base_ext;
    logic [LAG_W:0]    idx_ext;
    logic [IDX_W-1:0]  rd_idx;
    logic              alloc_found;

    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = !p_valid_reg || advance;
    assign accept   = s_tvalid && s_tready;

    assign cmd_in     = cmd_t'(s_tuser);
    assign word_in    = s_tdata[31:0];
    assign req_len_in = s_tdata[47:32];
    assign slot_in    = s_tdata[49:48];

    assign len_clamped = (req_len_in > REQ_LEN_W'(LINE_LEN_MAX)) ? LINE_LEN_MAX
                                                                 : LEN_W'(req_len_in);
    assign lag_sel  = lag_reg[slot_in];
    assign base_ext = (LAG_W + 1)'(wr_idx_reg);
    assign idx_ext  = (base_ext >= (LAG_W + 1)'(lag_sel))
                      ? base_ext - (LAG_W + 1)'(lag_sel)
                      : base_ext + (LAG_W + 1)'(DEPTH) - (LAG_W + 1)'(lag_sel);
    assign rd_idx   = idx_ext[IDX_W-1:0];

    always_comb begin
        wr_idx_next   = wr_idx_reg;
        fill_next     = fill_reg;
        active_next   = active_reg;
        for (int i = 0; i < READERS; i++) begin
            lag_next[i] = lag_reg[i];
        end
        p_status_next = ST_OK;
        p_slot_next   = '0;
        p_hit_next    = 1'b0;
        do_write      = 1'b0;
        do_read       = 1'b0;
        alloc_found   = 1'b0;
        case (cmd_in)
            CMD_WRITE: begin
                if (req_len_in == '0) begin
                    p_status_next = ST_EMPTY;
                end else begin
                    do_write    = 1'b1;
                    wr_idx_next = (32'(wr_idx_reg) + 1 >= DEPTH) ? '0 : wr_idx_reg + 1'b1;
                    if (fill_reg < DEPTH_L) begin
                        fill_next = fill_reg + 1'b1;
                    end
                    for (int i = 0; i < READERS; i++) begin
                        if (lag_reg[i] < DEPTH_L) begin
                            lag_next[i] = lag_reg[i] + 1'b1;
                        end
                    end
                end
            end
            CMD_ALLOC: begin
                p_status_next = ST_NO_READER;
                for (int i = 0; i < READERS; i++) begin
                    if (!alloc_found && !active_reg[i]) begin
                        alloc_found    = 1'b1;
                        active_next[i] = 1'b1;
                        lag_next[i]    = '0;
                        p_slot_next    = SLOT_W'(i);
                        p_status_next  = ST_OK;
                    end
                end
            end
            CMD_FREE: begin
                active_next[slot_in] = 1'b0;
            end
            CMD_READ: begin
                if (active_reg[slot_in] && lag_sel != '0) begin
                    do_read           = 1'b1;
                    p_hit_next        = 1'b1;
                    lag_next[slot_in] = lag_sel - 1'b1;
                end else begin
                    p_status_next = ST_NOTHING;
                end
            end
            default: begin
                p_status_next = ST_NOTHING;
            end
        endcase
        for (int i = 0; i < READERS; i++) begin
            p_pend_next[i] = active_next[i] && (lag_next[i] != '0);
        end
    end

    // Ring memory: at most one write or one read per accepted request.
    always_ff @(posedge aclk) begin
        if (accept && do_write) begin
            words_mem[wr_idx_reg]   <= word_in;
            lengths_mem[wr_idx_reg] <= len_clamped;
        end
        if (accept && do_read) begin
            rd_word_reg <= words_mem[rd_idx];
            rd_len_reg  <= lengths_mem[rd_idx];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_idx_reg  <= '0;
            fill_reg    <= '0;
            active_reg  <= '0;
            for (int i = 0; i < READERS; i++) begin
                lag_reg[i] <= '0;
            end
        end else if (accept) begin
            wr_idx_reg  <= wr_idx_next;
            fill_reg    <= fill_next;
            active_reg  <= active_next;
            for (int i = 0; i < READERS; i++) begin
                lag_reg[i] <= lag_next[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p_valid_reg <= 1'b0;
        end else if (s_tready) begin
            p_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            p_status_reg <= p_status_next;
            p_slot_reg   <= p_slot_next;
            p_hit_reg    <= p_hit_next;
            p_pend_reg   <= p_pend_next;
            p_fill_reg   <= FILL_W'(fill_next);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= p_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && p_valid_reg) begin
            out_status_reg <= p_status_reg;
            out_slot_reg   <= p_slot_reg;
            out_word_reg   <= p_hit_reg ? rd_word_reg : '0;
            out_len_reg    <= p_hit_reg ? rd_len_reg : '0;
            out_pend_reg   <= p_pend_reg;
            out_fill_reg   <= p_fill_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_fill_reg, out_pend_reg, out_len_reg, out_word_reg,
                       out_slot_reg, out_status_reg};

endmodule

`default_nettype wire

// ===== src/mrow_checker.sv =====
// Port-level checker for the multi-reader overwrite ring, with its bind.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module mrow_checker
    import mrow_pkg::*;
(
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [55:0] m_tdata
);

    logic stall;
    logic not_ok;
    logic no_read_data;

    assign stall        = m_tvalid && !m_tready;
    assign not_ok       = m_tdata[1:0] != ST_OK;
    assign no_read_data = (m_tdata[35:4] == '0) && (m_tdata[43:36] == '0);

    `ASSERT_CLK(a_valid_holds, aclk, aresetn, stall |=> m_tvalid, "result request dropped")
    `ASSERT_HOLD(a_data_holds, aclk, aresetn, stall, m_tdata, "stalled result changed")
    `ASSERT_CLK(a_fail_no_data, aclk, aresetn, (m_tvalid && not_ok) |-> no_read_data, "read data on failed request")
    `ASSERT_CLK(a_grant_ok, aclk, aresetn, (m_tvalid && m_tdata[3:2] != '0) |-> !not_ok, "slot granted on failed request")
    `ASSERT_CLK(a_len_ok, aclk, aresetn, (m_tvalid && m_tdata[43:36] != '0) |-> (m_tdata[3:2] == '0), "read result carries a granted slot")

endmodule

bind multi_reader_overwrite_ring mrow_checker u_mrow_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
